// ===== hw/rtl/scp_pkg.sv =====
`timescale 1ns / 1ps

package scp_pkg;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ACC,
        ST_SCAN_RD,
        ST_SCAN_MUL,
        ST_SCAN_CMP,
        ST_DECIDE,
        ST_UPD,
        ST_DONE
    } state_t;

    localparam int THR_W   = 41;
    localparam int TOK_W   = 7;
    localparam int WGT_W   = 8;
    localparam int SUM_W   = 18;
    localparam int CNT_W   = 11;
    localparam int DOT_W   = 33;
    localparam int DOUT_W  = 24;

    localparam logic [SUM_W-1:0] SUM_MAX   = '1;
    localparam logic [CNT_W-1:0] COUNT_MAX = '1;
    localparam logic [TOK_W-1:0] TOKEN_COUNT_RESET = 7'd64;

    localparam logic REG_THRESHOLD   = 1'b0;
    localparam logic REG_TOKEN_COUNT = 1'b1;

endpackage

// ===== hw/rtl/scp_store.sv =====
`timescale 1ns / 1ps

module scp_store #(
    parameter int PW = 6,
    parameter int CW = 6
) (
    input  logic                         clk,
    input  logic                         doc_we,
    input  logic [PW-1:0]                doc_waddr,
    input  logic [scp_pkg::WGT_W-1:0]    doc_wdata,
    input  logic [PW-1:0]                doc_raddr,
    output logic [scp_pkg::WGT_W-1:0]    doc_rdata,
    input  logic                         cen_we,
    input  logic [CW+PW-1:0]             cen_waddr,
    input  logic [scp_pkg::SUM_W-1:0]    cen_wdata,
    input  logic [CW+PW-1:0]             cen_raddr,
    output logic [scp_pkg::SUM_W-1:0]    cen_rdata,
    input  logic                         dot_we,
    input  logic [CW-1:0]                dot_waddr,
    input  logic [scp_pkg::DOT_W-1:0]    dot_wdata,
    input  logic [CW-1:0]                dot_raddr,
    output logic [scp_pkg::DOT_W-1:0]    dot_rdata,
    input  logic                         cnt_we,
    input  logic [CW-1:0]                cnt_waddr,
    input  logic [scp_pkg::CNT_W-1:0]    cnt_wdata,
    input  logic [CW-1:0]                cnt_raddr,
    output logic [scp_pkg::CNT_W-1:0]    cnt_rdata
);

    logic [scp_pkg::WGT_W-1:0] doc_mem [2**PW];
    logic [scp_pkg::SUM_W-1:0] cen_mem [2**(CW+PW)];
    logic [scp_pkg::DOT_W-1:0] dot_mem [2**CW];
    logic [scp_pkg::CNT_W-1:0] cnt_mem [2**CW];

    always_ff @(posedge clk)
    begin
        if (doc_we)
        begin
            doc_mem[doc_waddr] <= doc_wdata;
        end
        doc_rdata <= doc_mem[doc_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cen_we)
        begin
            cen_mem[cen_waddr] <= cen_wdata;
        end
        cen_rdata <= cen_mem[cen_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dot_we)
        begin
            dot_mem[dot_waddr] <= dot_wdata;
        end
        dot_rdata <= dot_mem[dot_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (cnt_we)
        begin
            cnt_mem[cnt_waddr] <= cnt_wdata;
        end
        cnt_rdata <= cnt_mem[cnt_raddr];
    end

endmodule

// ===== hw/rtl/scp_judge.sv =====
`timescale 1ns / 1ps

// Registers the cross products of one cluster's similarity test, then compares.
module scp_judge (
    input  logic                         clk,
    input  logic                         load,
    input  logic [scp_pkg::DOT_W-1:0]    dot_in,
    input  logic [scp_pkg::CNT_W-1:0]    cnt_in,
    input  logic [scp_pkg::DOT_W-1:0]    best_dot,
    input  logic [scp_pkg::CNT_W-1:0]    best_cnt,
    input  logic [scp_pkg::THR_W-1:0]    thr,
    output logic                         match,
    output logic                         better,
    output logic [scp_pkg::DOT_W-1:0]    dot_q,
    output logic [scp_pkg::CNT_W-1:0]    cnt_q
);

    localparam int TP_W = scp_pkg::THR_W + scp_pkg::CNT_W;
    localparam int XP_W = scp_pkg::DOT_W + scp_pkg::CNT_W;

    logic [TP_W-1:0] thr_prod_reg;
    logic [XP_W-1:0] cand_prod_reg;
    logic [XP_W-1:0] best_prod_reg;

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            thr_prod_reg  <= thr * cnt_in;
            cand_prod_reg <= dot_in * best_cnt;
            best_prod_reg <= best_dot * cnt_in;
            dot_q         <= dot_in;
            cnt_q         <= cnt_in;
        end
    end

    // dot / cnt > thr / 256, tested as dot * 256 > thr * cnt.
    assign match  = (cnt_q != '0) && (TP_W'({dot_q, 8'd0}) > thr_prod_reg);
    assign better = cand_prod_reg > best_prod_reg;

endmodule

// ===== hw/rtl/single_pass_centroid_clustering.sv =====
`timescale 1ns / 1ps

// A term that does not end a document is accepted in ST_IDLE, then ST_ACC does one
// dot-accumulator read-modify-write per open cluster through the memory ports.
// The last term adds a cluster scan (read, multiply, compare per cluster), the centroid
// update and the load of the output register, where the result waits.
// Reset (rst_n, asynchronous, active low) empties the cluster store, zeroes the term and
// document counters, and sets the threshold to 0 and the token count to 64.
module single_pass_centroid_clustering #(
    parameter int MAX_TERMS    = 64,
    parameter int MAX_CLUSTERS = 64,
    parameter int MAX_DOCS     = 1024
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [7:0]                    s_axis_tdata,   // term_weight
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [scp_pkg::DOUT_W-1:0]    m_axis_tdata,   // doc_index, cluster_id,
                                                          // opened_new, store_full, zeros
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [0:0]                    cfg_index,
    input  logic [scp_pkg::THR_W-1:0]     cfg_data
);

    localparam int PW   = (MAX_TERMS > 1) ? $clog2(MAX_TERMS) : 1;
    localparam int LENW = PW + 1;
    localparam int CW   = (MAX_CLUSTERS > 1) ? $clog2(MAX_CLUSTERS) : 1;
    localparam int CTW  = $clog2(MAX_CLUSTERS + 1);
    localparam int DW   = $clog2(MAX_DOCS);

    scp_pkg::state_t state_reg, state_next;

    logic [scp_pkg::THR_W-1:0] thr_reg;
    logic [scp_pkg::TOK_W-1:0] tok_reg;
    logic [PW-1:0]             pos_reg;
    logic [DW-1:0]             doc_cnt_reg;
    logic [CTW-1:0]            total_reg;
    logic [scp_pkg::WGT_W-1:0] w_reg;
    logic                      last_reg;
    logic [CTW-1:0]            c_reg;
    logic                      pv_reg;
    logic [CW-1:0]             pidx_reg;
    logic [LENW-1:0]           t_reg;
    logic [PW-1:0]             pt_reg;
    logic                      found_reg;
    logic [CW-1:0]             best_reg;
    logic [scp_pkg::DOT_W-1:0] best_dot_reg;
    logic [scp_pkg::CNT_W-1:0] best_cnt_reg;
    logic                      out_valid_reg;
    logic [9:0]                out_doc_reg;
    logic [5:0]                out_cid_reg;
    logic                      out_new_reg;
    logic                      out_full_reg;

    logic [LENW-1:0]           len;
    logic                      is_last;
    logic                      in_fire;
    logic                      acc_issue;
    logic                      upd_issue;
    logic [LENW-1:0]           upd_lim;
    logic                      room;
    logic [CW-1:0]             upd_c;
    logic                      take;

    logic                      doc_we;
    logic [scp_pkg::WGT_W-1:0] doc_rdata;
    logic                      cen_we;
    logic [CW+PW-1:0]          cen_raddr;
    logic [scp_pkg::SUM_W-1:0] cen_wdata;
    logic [scp_pkg::SUM_W-1:0] cen_rdata;
    logic                      dot_we;
    logic [scp_pkg::DOT_W-1:0] dot_wdata;
    logic [scp_pkg::DOT_W-1:0] dot_rdata;
    logic                      cnt_we;
    logic [scp_pkg::CNT_W-1:0] cnt_wdata;
    logic [scp_pkg::CNT_W-1:0] cnt_rdata;
    logic [25:0]               term_prod;
    logic [scp_pkg::SUM_W:0]   sum_ext;

    logic                      j_match;
    logic                      j_better;
    logic [scp_pkg::DOT_W-1:0] j_dot;
    logic [scp_pkg::CNT_W-1:0] j_cnt;

    always_comb
    begin
        if (tok_reg == '0)
        begin
            len = LENW'(1);
        end
        else if (32'(tok_reg) > MAX_TERMS)
        begin
            len = LENW'(MAX_TERMS);
        end
        else
        begin
            len = LENW'(tok_reg);
        end
    end

    assign is_last   = (LENW'(pos_reg) + LENW'(1)) >= len;
    assign s_axis_tready = (state_reg == scp_pkg::ST_IDLE) && !(out_valid_reg && is_last);
    assign in_fire   = s_axis_tvalid && s_axis_tready;
    assign acc_issue = (state_reg == scp_pkg::ST_ACC) && (c_reg < total_reg);
    assign upd_lim   = found_reg ? len : LENW'(MAX_TERMS);
    assign upd_issue = (state_reg == scp_pkg::ST_UPD) && (t_reg < upd_lim);
    assign room      = 32'(total_reg) < MAX_CLUSTERS;
    assign upd_c     = found_reg ? best_reg : CW'(total_reg);
    assign take      = j_match && (!found_reg || j_better);
    // Registers change only between terms, never while a term is being worked on.
    assign cfg_ready = (state_reg == scp_pkg::ST_IDLE);

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            scp_pkg::ST_IDLE:
            begin
                if (in_fire)
                begin
                    state_next = scp_pkg::ST_ACC;
                end
            end
            scp_pkg::ST_ACC:
            begin
                if (!acc_issue && !pv_reg)
                begin
                    state_next = last_reg ? scp_pkg::ST_SCAN_RD : scp_pkg::ST_IDLE;
                end
            end
            scp_pkg::ST_SCAN_RD:
            begin
                state_next = (c_reg < total_reg) ? scp_pkg::ST_SCAN_MUL : scp_pkg::ST_DECIDE;
            end
            scp_pkg::ST_SCAN_MUL: state_next = scp_pkg::ST_SCAN_CMP;
            scp_pkg::ST_SCAN_CMP: state_next = scp_pkg::ST_SCAN_RD;
            scp_pkg::ST_DECIDE:
            begin
                state_next = (found_reg || room) ? scp_pkg::ST_UPD : scp_pkg::ST_DONE;
            end
            scp_pkg::ST_UPD:
            begin
                if (!upd_issue && !pv_reg)
                begin
                    state_next = scp_pkg::ST_DONE;
                end
            end
            scp_pkg::ST_DONE:     state_next = scp_pkg::ST_IDLE;
        endcase
    end

    // Memory port control.
    always_comb
    begin
        sum_ext   = {1'b0, cen_rdata} + (scp_pkg::SUM_W + 1)'(doc_rdata);
        term_prod = w_reg * cen_rdata;
        doc_we    = in_fire;
        cen_raddr = (state_reg == scp_pkg::ST_ACC) ? {CW'(c_reg), pos_reg}
                                                   : {upd_c, PW'(t_reg)};
        cen_we    = (state_reg == scp_pkg::ST_UPD) && pv_reg;
        if (found_reg)
        begin
            cen_wdata = sum_ext[scp_pkg::SUM_W] ? scp_pkg::SUM_MAX
                                                : sum_ext[scp_pkg::SUM_W-1:0];
        end
        else
        begin
            cen_wdata = (LENW'(pt_reg) < len) ? scp_pkg::SUM_W'(doc_rdata) : '0;
        end
        dot_we    = (state_reg == scp_pkg::ST_ACC) && pv_reg;
        // The first term of a document starts every accumulator from zero.
        dot_wdata = ((pos_reg == '0) ? '0 : dot_rdata) + scp_pkg::DOT_W'(term_prod);
        cnt_we    = (state_reg == scp_pkg::ST_DECIDE) && (found_reg || room);
        if (found_reg)
        begin
            cnt_wdata = (best_cnt_reg == scp_pkg::COUNT_MAX) ? scp_pkg::COUNT_MAX
                                                             : best_cnt_reg + 1'b1;
        end
        else
        begin
            cnt_wdata = scp_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= scp_pkg::ST_IDLE;
            thr_reg       <= '0;
            tok_reg       <= scp_pkg::TOKEN_COUNT_RESET;
            pos_reg       <= '0;
            doc_cnt_reg   <= '0;
            total_reg     <= '0;
            last_reg      <= 1'b0;
            c_reg         <= '0;
            pv_reg        <= 1'b0;
            t_reg         <= '0;
            found_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_valid && cfg_ready)
            begin
                if (cfg_index == scp_pkg::REG_THRESHOLD)
                begin
                    thr_reg <= cfg_data;
                end
                else
                begin
                    tok_reg <= cfg_data[scp_pkg::TOK_W-1:0];
                end
            end
            if (state_reg == scp_pkg::ST_DONE)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && m_axis_tready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                scp_pkg::ST_IDLE:
                begin
                    if (in_fire)
                    begin
                        last_reg <= is_last;
                        c_reg    <= '0;
                        pv_reg   <= 1'b0;
                    end
                end
                scp_pkg::ST_ACC:
                begin
                    pv_reg <= acc_issue;
                    if (acc_issue)
                    begin
                        c_reg <= c_reg + 1'b1;
                    end
                    if (!acc_issue && !pv_reg)
                    begin
                        c_reg     <= '0;
                        found_reg <= 1'b0;
                        if (!last_reg)
                        begin
                            pos_reg <= pos_reg + 1'b1;
                        end
                    end
                end
                scp_pkg::ST_SCAN_CMP:
                begin
                    if (take)
                    begin
                        found_reg <= 1'b1;
                    end
                    c_reg <= c_reg + 1'b1;
                end
                scp_pkg::ST_DECIDE:
                begin
                    t_reg  <= '0;
                    pv_reg <= 1'b0;
                end
                scp_pkg::ST_UPD:
                begin
                    pv_reg <= upd_issue;
                    if (upd_issue)
                    begin
                        t_reg <= t_reg + 1'b1;
                    end
                end
                scp_pkg::ST_DONE:
                begin
                    if (!found_reg && room)
                    begin
                        total_reg <= total_reg + 1'b1;
                    end
                    pos_reg <= '0;
                    if (32'(doc_cnt_reg) == MAX_DOCS - 1)
                    begin
                        doc_cnt_reg <= '0;
                    end
                    else
                    begin
                        doc_cnt_reg <= doc_cnt_reg + 1'b1;
                    end
                end
                default:
                begin
                end
            endcase
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            w_reg <= s_axis_tdata;
        end
        if (state_reg == scp_pkg::ST_ACC)
        begin
            pidx_reg <= CW'(c_reg);
        end
        if (state_reg == scp_pkg::ST_UPD)
        begin
            pt_reg <= PW'(t_reg);
        end
        if ((state_reg == scp_pkg::ST_SCAN_CMP) && take)
        begin
            best_reg     <= CW'(c_reg);
            best_dot_reg <= j_dot;
            best_cnt_reg <= j_cnt;
        end
        if (state_reg == scp_pkg::ST_DONE)
        begin
            out_doc_reg  <= 10'(doc_cnt_reg);
            out_new_reg  <= !found_reg && room;
            out_full_reg <= !found_reg && !room;
            if (found_reg)
            begin
                out_cid_reg <= 6'(best_reg);
            end
            else if (room)
            begin
                out_cid_reg <= 6'(total_reg);
            end
            else
            begin
                out_cid_reg <= '0;
            end
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {6'd0, out_full_reg, out_new_reg, out_cid_reg, out_doc_reg};

    scp_store #(
        .PW (PW),
        .CW (CW)
    ) u_store (
        .clk       (clk),
        .doc_we    (doc_we),
        .doc_waddr (pos_reg),
        .doc_wdata (s_axis_tdata),
        .doc_raddr (PW'(t_reg)),
        .doc_rdata (doc_rdata),
        .cen_we    (cen_we),
        .cen_waddr ({upd_c, pt_reg}),
        .cen_wdata (cen_wdata),
        .cen_raddr (cen_raddr),
        .cen_rdata (cen_rdata),
        .dot_we    (dot_we),
        .dot_waddr (pidx_reg),
        .dot_wdata (dot_wdata),
        .dot_raddr (CW'(c_reg)),
        .dot_rdata (dot_rdata),
        .cnt_we    (cnt_we),
        .cnt_waddr (upd_c),
        .cnt_wdata (cnt_wdata),
        .cnt_raddr (CW'(c_reg)),
        .cnt_rdata (cnt_rdata)
    );

    scp_judge u_judge (
        .clk      (clk),
        .load     (state_reg == scp_pkg::ST_SCAN_MUL),
        .dot_in   (dot_rdata),
        .cnt_in   (cnt_rdata),
        .best_dot (best_dot_reg),
        .best_cnt (best_cnt_reg),
        .thr      (thr_reg),
        .match    (j_match),
        .better   (j_better),
        .dot_q    (j_dot),
        .cnt_q    (j_cnt)
    );

endmodule

// ===== hw/rtl/scp_checker.sv =====
`timescale 1ns / 1ps

module scp_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_axis_tvalid,
    input logic                          s_axis_tready,
    input logic                          m_axis_tvalid,
    input logic                          m_axis_tready,
    input logic [scp_pkg::DOUT_W-1:0]    m_axis_tdata
);

    // A stalled result holds its payload.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // A dropped document reports cluster 0 and never opens a cluster.
    a_full_fields: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[17] |-> m_axis_tdata[16] == 1'b0
                                            && m_axis_tdata[15:10] == 6'd0)
        else $error("store_full result carries a cluster");

    // A result rises only after the work of a document, never directly after a term transfer.
    a_result_gap: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> !$past(s_axis_tvalid && s_axis_tready))
        else $error("result raised right after a transfer");

    // The padding bits of the result stay zero.
    a_pad_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> m_axis_tdata[23:18] == 6'd0)
        else $error("padding bits set");

endmodule

bind single_pass_centroid_clustering scp_checker u_scp_checker (.*);

// ===== tb/sv/tb_single_pass_centroid_clustering.sv =====
`timescale 1ns / 1ps

module tb_single_pass_centroid_clustering;

    localparam int N_TERMS    = 64;
    localparam int N_CLUSTERS = 64;
    localparam int N_DOCS     = 1024;
    localparam int SETTLE     = 400;
    localparam logic [scp_pkg::THR_W-1:0] THR_TOP = '1;

    typedef struct packed {
        logic       store_full;
        logic       opened_new;
        logic [5:0] cluster_id;
        logic [9:0] doc_index;
    } doc_result_t;

    typedef enum logic { ROW_CFG, ROW_TERM } row_kind_t;

    typedef struct {
        row_kind_t                   kind;
        logic                        index;
        logic [scp_pkg::THR_W-1:0]   value;
        bit                          typed;
        doc_result_t                 result;
    } stim_row_t;

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [7:0]                    s_axis_tdata = '0;
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [scp_pkg::DOUT_W-1:0]    m_axis_tdata;
    logic                          cfg_valid = 1'b0;
    logic                          cfg_ready;
    logic [0:0]                    cfg_index = '0;
    logic [scp_pkg::THR_W-1:0]     cfg_data = '0;

    single_pass_centroid_clustering DUT (
        .clk(clk), .rst_n(rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #50ms;
        $display("Mismatches found");
        $finish;
    end

    // Shadow copy of the clustering state.
    logic [scp_pkg::THR_W-1:0]   sim_threshold;
    logic [scp_pkg::TOK_W-1:0]   terms_per_doc;
    logic [7:0]                  doc_weights [N_TERMS];
    logic [scp_pkg::SUM_W-1:0]   sum_vectors [N_CLUSTERS][N_TERMS];
    logic [scp_pkg::CNT_W-1:0]   members [N_CLUSTERS];
    longint unsigned             dots [N_CLUSTERS];
    int                          open_clusters;
    int                          term_pos;
    int                          doc_num;

    doc_result_t        pending_docs [$];
    int                 mismatches = 0;
    int                 terms_sent = 0;
    int                 tx_idle_pct = 19;
    int                 rx_idle_pct = 87;
    stim_row_t          directed [$];

    function automatic void classify_term(input logic [7:0] w, output bit done,
                                          output doc_result_t res);
        int pos, len, best;
        bit found;
        longint unsigned dot, cnt, s;
        pos = term_pos % N_TERMS;
        len = (terms_per_doc == 0) ? 1 : (terms_per_doc > N_TERMS) ? N_TERMS : terms_per_doc;
        doc_weights[pos] = w;
        for (int c = 0; c < open_clusters; c++)
            dots[c] += longint'(w) * sum_vectors[c][pos];
        done = 1'b0;
        res = '0;
        if (pos + 1 < len)
        begin
            term_pos = pos + 1;
            return;
        end
        found = 1'b0;
        best = 0;
        for (int c = 0; c < open_clusters; c++)
        begin
            dot = dots[c];
            cnt = members[c];
            if (cnt == 0 || !(dot * 256 > longint'(sim_threshold) * cnt))
                continue;
            if (!found || dot * members[best] > dots[best] * cnt)
            begin
                best = c;
                found = 1'b1;
            end
        end
        done = 1'b1;
        res.doc_index = doc_num[9:0];
        if (found)
        begin
            for (int t = 0; t < len; t++)
            begin
                s = longint'(sum_vectors[best][t]) + doc_weights[t];
                sum_vectors[best][t] = (s > scp_pkg::SUM_MAX) ? scp_pkg::SUM_MAX
                                                              : s[scp_pkg::SUM_W-1:0];
            end
            if (members[best] < scp_pkg::COUNT_MAX)
                members[best]++;
            res.cluster_id = best[5:0];
        end
        else if (open_clusters < N_CLUSTERS)
        begin
            for (int t = 0; t < N_TERMS; t++)
                sum_vectors[open_clusters][t] = (t < len) ? scp_pkg::SUM_W'(doc_weights[t])
                                                          : '0;
            members[open_clusters] = scp_pkg::CNT_W'(1);
            res.cluster_id = open_clusters[5:0];
            res.opened_new = 1'b1;
            open_clusters++;
        end
        else
            res.store_full = 1'b1;
        for (int c = 0; c < N_CLUSTERS; c++)
            dots[c] = 0;
        term_pos = 0;
        doc_num = (doc_num + 1) % N_DOCS;
    endfunction

    always @(posedge clk)
        m_axis_tready <= ($urandom_range(99) >= rx_idle_pct);

    always @(posedge clk)
    begin
        doc_result_t got, want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got = m_axis_tdata[17:0];
            if (pending_docs.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result transfer: %h", m_axis_tdata);
            end
            else
            begin
                want = pending_docs.pop_front();
                if (got !== want || m_axis_tdata[scp_pkg::DOUT_W-1:18] !== '0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("doc %0d: expected cid %0d new %b full %b, ",
                                 want.doc_index, want.cluster_id, want.opened_new,
                                 want.store_full,
                                 "got doc %0d cid %0d new %b full %b pad %h",
                                 got.doc_index, got.cluster_id, got.opened_new,
                                 got.store_full, m_axis_tdata[scp_pkg::DOUT_W-1:18]);
                end
            end
        end
    end

    task automatic send_term(input logic [7:0] w, output bit done, output doc_result_t res);
        tx_idle_pct = (terms_sent < 500) ? 19 : (terms_sent < 1000) ? 87 : 0;
        rx_idle_pct = (terms_sent < 500) ? 87 : (terms_sent < 1000) ? 19 : 0;
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata <= w;
        do @(posedge clk); while (!s_axis_tready);
        terms_sent++;
        classify_term(w, done, res);
    endtask

    // Registers change only once every document result is back and the block has settled.
    task automatic write_reg(input logic index, input logic [scp_pkg::THR_W-1:0] value);
        s_axis_tvalid <= 1'b0;
        while (pending_docs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= value;
        do @(posedge clk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        if (index == scp_pkg::REG_THRESHOLD)
            sim_threshold = value;
        else
            terms_per_doc = value[scp_pkg::TOK_W-1:0];
    endtask

    function automatic logic [7:0] pick_weight();
        case ($urandom_range(3))
            0: return 8'd0;
            1: return 8'd255;
            default: return 8'($urandom_range(255));
        endcase
    endfunction

    task automatic add_row(input row_kind_t kind, input logic index,
                           input logic [scp_pkg::THR_W-1:0] value,
                           input bit typed, input doc_result_t result);
        stim_row_t r;
        r.kind = kind;
        r.index = index;
        r.value = value;
        r.typed = typed;
        r.result = result;
        directed = {directed, r};
    endtask

    initial
    begin
        bit done;
        doc_result_t res;
        logic [scp_pkg::THR_W-1:0] thr;
        int ntok, count;

        sim_threshold = '0;
        terms_per_doc = scp_pkg::TOKEN_COUNT_RESET;
        open_clusters = 0;
        term_pos = 0;
        doc_num = 0;
        for (int c = 0; c < N_CLUSTERS; c++)
            dots[c] = 0;

        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd1, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd0, 1'b1, '{1'b0, 1'b1, 6'd0, 10'd0});
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b1, '{1'b0, 1'b1, 6'd1, 10'd1});
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b1, '{1'b0, 1'b0, 6'd1, 10'd2});
        add_row(ROW_CFG, scp_pkg::REG_THRESHOLD, THR_TOP, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd1, 1'b1, '{1'b0, 1'b1, 6'd2, 10'd3});
        add_row(ROW_CFG, scp_pkg::REG_THRESHOLD, 41'd0, 1'b0, '0);
        // A token count of zero acts as one term per document.
        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd0, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd128, 1'b0, '0);
        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd127, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd0, 1'b0, '0);
        // Shortening the document mid-way ends it at the next term.
        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd3, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd77, 1'b0, '0);
        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd4, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd1, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd254, 1'b0, '0);
        add_row(ROW_CFG, scp_pkg::REG_TOKEN_COUNT, 41'd2, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd128, 1'b0, '0);
        add_row(ROW_CFG, scp_pkg::REG_THRESHOLD, 41'h1, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b0, '0);
        add_row(ROW_TERM, 1'b0, 41'd255, 1'b0, '0);

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            if (directed[i].kind == ROW_CFG)
                write_reg(directed[i].index, directed[i].value);
            else
            begin
                send_term(directed[i].value[7:0], done, res);
                if (done)
                    pending_docs = {pending_docs,
                                    directed[i].typed ? directed[i].result : res};
            end
        end

        for (int phase = 0; phase < 6; phase++)
        begin
            case (phase)
                0: begin thr = 41'($urandom_range(65535)); ntok = $urandom_range(8, 1);
                         count = 300; end
                1: begin thr = THR_TOP; ntok = 3; count = 200; end
                2: begin thr = '0; ntok = 1; count = 500; end
                3: begin thr = 41'($urandom_range(1 << 20)); ntok = 127; count = 130; end
                4: begin thr = {9'($urandom), 32'($urandom)}; ntok = 0; count = 100; end
                default: begin thr = {9'($urandom), 32'($urandom)} >> $urandom_range(40);
                               ntok = $urandom_range(6, 1); count = 270; end
            endcase
            write_reg(scp_pkg::REG_THRESHOLD, thr);
            write_reg(scp_pkg::REG_TOKEN_COUNT, 41'(ntok));
            for (int i = 0; i < count; i++)
            begin
                send_term((phase == 2 && $urandom_range(9) != 0) ? 8'd255 : pick_weight(),
                          done, res);
                if (done)
                    pending_docs = {pending_docs, res};
            end
        end

        s_axis_tvalid <= 1'b0;
        while (pending_docs.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule
